FILE: hdl/lsfe_pkg.sv
// lsfe_pkg: shared types, constants and helper functions for the led strip frame encoder
// no dependencies; used by every module of the block and by its checker
package lsfe_pkg;

  localparam int unsigned ColourW = 24;
  localparam int unsigned CodedW  = 40;

  localparam logic [4:0]         CodeZero    = 5'b10000;
  localparam logic [4:0]         CodeOne     = 5'b11110;
  localparam logic [ColourW-1:0] ResetColour = 24'h530000;
  localparam logic [CodedW-1:0]  CodeDark    = {8{CodeZero}};

  localparam logic [1:0] ChGreen = 2'd0;
  localparam logic [1:0] ChRed   = 2'd1;
  localparam logic [1:0] ChBlue  = 2'd2;

  typedef enum logic {
    ReqTick = 1'b0,
    ReqLoad = 1'b1
  } req_type_e;

  typedef struct packed {
    logic               req_type;
    logic [ColourW-1:0] colour;
  } req_t;

  typedef struct packed {
    logic [CodedW-1:0] coded_bits;
    logic [3:0]        led_index;
    logic [1:0]        channel;
    logic              last;
  } res_t;

  // floor(x / 3) for an 8-bit x as multiply by reciprocal
  function automatic logic [7:0] div3(input logic [7:0] x);
    logic [15:0] prod;
    prod = x * 8'd171;
    return 8'(prod >> 9);
  endfunction

  // msb first, one 5-bit code per bit
  function automatic logic [CodedW-1:0] code_byte(input logic [7:0] b);
    logic [CodedW-1:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc[k*5 +: 5] = b[k] ? CodeOne : CodeZero;
    end
    return acc;
  endfunction

endpackage

FILE: hdl/lsfe_front.sv
// lsfe_front: accepts requests, updates the held colour and pushes the dimmed grb word
// depends on lsfe_pkg
module lsfe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  lsfe_pkg::req_t               req_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic [lsfe_pkg::ColourW-1:0] q_data_o
);

  logic [lsfe_pkg::ColourW-1:0] colour_q, colour_d;

  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    colour_d = colour_q;
    if (q_push_o) begin
      if (req_i.req_type == lsfe_pkg::ReqLoad) begin
        colour_d = req_i.colour;
      end else begin
        colour_d = {colour_q[lsfe_pkg::ColourW-2:0], colour_q[lsfe_pkg::ColourW-1]};
      end
    end
  end

  // rgb to grb with each channel divided by three
  assign q_data_o = {lsfe_pkg::div3(colour_d[15:8]),
                     lsfe_pkg::div3(colour_d[23:16]),
                     lsfe_pkg::div3(colour_d[7:0])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= lsfe_pkg::ResetColour;
    end else begin
      colour_q <= colour_d;
    end
  end

endmodule

FILE: hdl/lsfe_queue.sv
// lsfe_queue: two-entry queue of dimmed grb words between front and back
// depends on lsfe_pkg
module lsfe_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [lsfe_pkg::ColourW-1:0] data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic                         valid_o,
  output logic [lsfe_pkg::ColourW-1:0] data_o
);

  logic [lsfe_pkg::ColourW-1:0] mem_q [2];
  logic                         wr_ptr_q, rd_ptr_q;
  logic [1:0]                   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

FILE: hdl/lsfe_back.sv
// lsfe_back: walks leds and channels of the queued colour, one coded result per cycle while pop keeps up
// depends on lsfe_pkg
module lsfe_back #(
  parameter int unsigned NUM_LEDS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  logic [lsfe_pkg::ColourW-1:0] q_data_i,
  output logic                         q_pop_o,
  output logic                         empty,
  input  logic                         pop,
  output lsfe_pkg::res_t               res_o
);

  localparam int unsigned LedW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LedW-1:0] LedLast = LedW'(NUM_LEDS - 1);

  logic [LedW-1:0] led_q, led_d;
  logic [1:0]      ch_q, ch_d;
  logic            out_valid_q, out_valid_d;
  lsfe_pkg::res_t  res_q, res_d;
  logic            advance, frame_end;
  logic [4:0]      led_wide;
  logic [7:0]      byte_sel;

  assign advance   = q_valid_i && (!out_valid_q || pop);
  assign frame_end = (led_q == LedLast) && (ch_q == lsfe_pkg::ChBlue);
  assign q_pop_o   = advance && frame_end;
  assign led_wide  = 5'(led_q);

  always_comb begin
    case (ch_q)
      lsfe_pkg::ChGreen: byte_sel = q_data_i[23:16];
      lsfe_pkg::ChRed:   byte_sel = q_data_i[15:8];
      lsfe_pkg::ChBlue:  byte_sel = q_data_i[7:0];
      default:           byte_sel = 8'd0;
    endcase
    if (!led_wide[1]) begin
      byte_sel = 8'd0;
    end
  end

  always_comb begin
    res_d            = res_q;
    res_d.coded_bits = lsfe_pkg::code_byte(byte_sel);
    res_d.led_index  = 4'(led_q);
    res_d.channel    = ch_q;
    res_d.last       = frame_end;
  end

  always_comb begin
    led_d = led_q;
    ch_d  = ch_q;
    if (advance) begin
      if (ch_q == lsfe_pkg::ChBlue) begin
        ch_d  = lsfe_pkg::ChGreen;
        led_d = frame_end ? '0 : led_q + 1'b1;
      end else begin
        ch_d = ch_q + 2'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q       <= '0;
      ch_q        <= lsfe_pkg::ChGreen;
      out_valid_q <= 1'b0;
    end else begin
      led_q       <= led_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty = !out_valid_q;
  assign res_o = res_q;

endmodule

FILE: hdl/led_strip_frame_encoder.sv
// led_strip_frame_encoder: top level, front end, request queue and frame sequencer
// depends on lsfe_pkg, lsfe_front, lsfe_queue, lsfe_back
//
// usage:
//   requests enter as a queue: drive req_i and raise push; a transfer happens
//   at a rising edge with push high and full low. a tick rotates the held
//   colour left by one bit, a load replaces it; each request then yields one
//   frame of 3*NUM_LEDS results (green, red, blue per led, leds ascending),
//   the final one flagged by res_o.last.
//   results leave as a queue: res_o is valid while empty is low and is
//   transferred at a rising edge with pop high and empty low.
//   path: the first result of a frame goes from its request transfer through
//   the queue into the result register when the sequencer is free. throughput:
//   one result per cycle while pop keeps up, set by the frame sequencer; the
//   queue holds the running frame's colour and one waiting colour, so the
//   front accepts one request ahead of the running frame.
//   stall: with pop low and a result waiting the result register holds and
//   the sequencer pauses; full rises once a frame runs and another waits.
//   reset: the colour returns to 0x530000, queue and result register empty.
module led_strip_frame_encoder #(
  parameter int unsigned NUM_LEDS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  lsfe_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output lsfe_pkg::res_t res_o
);

  logic                         q_push, q_full, q_pop, q_valid;
  logic [lsfe_pkg::ColourW-1:0] q_wdata, q_rdata;

  lsfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .req_i    (req_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  lsfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  lsfe_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

  assign full = q_full;

endmodule

FILE: hdl/lsfe_checker.sv
// lsfe_checker: port-level assertions for led_strip_frame_encoder, bound to the top level
// depends on lsfe_pkg and led_strip_frame_encoder
module lsfe_checker #(
  parameter int unsigned NUM_LEDS = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input lsfe_pkg::res_t res_o
);

  // nothing waits during reset
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // a waiting result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(res_o))
    else $error("waiting result changed");

  // frame ends on the blue channel of the final led
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_o.last |->
      res_o.channel == lsfe_pkg::ChBlue && res_o.led_index == 4'(NUM_LEDS - 1))
    else $error("last flag on wrong result");

  // dark leds carry only zero codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !res_o.led_index[1] |-> res_o.coded_bits == lsfe_pkg::CodeDark)
    else $error("dark led not black");

endmodule

bind led_strip_frame_encoder lsfe_checker #(
  .NUM_LEDS (NUM_LEDS)
) u_lsfe_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);
